// ===== src/bpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and types for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int BPE_MAX_POINTS  = 16;
  localparam int BPE_COORD_BITS  = 32;
  localparam int BPE_T_FRAC_BITS = 16;

  localparam int INDEX_BITS  = 4;
  localparam int DEGREE_BITS = 4;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic                   MODE_LOAD = 1'b0;
  localparam logic                   MODE_EVAL = 1'b1;
  localparam logic                   REG_CURVE_DEGREE = 1'b0;
  localparam logic [DEGREE_BITS-1:0] CURVE_DEGREE_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } bpe_state_t;

endpackage

// ===== src/bezier_point_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator_top
// Throughput: loads go back to back; an evaluate holds the input until its
//   result is loaded, set by one memory read per cycle and a pipeline drain
//   per level. Reset: rst is synchronous; it clears control state and sets
//   curve_degree to 3. The point store has no reset and is undefined until written.
// ----------------------------------------------------------------------------
// Evaluates a 2-D Bezier curve by de Casteljau's algorithm.
//
// Two synchronous memories hold the state. The point store keeps the
// control points as loaded; the work store holds the intermediate points of
// the interpolation triangle. Each entry packs x in the upper half and y in
// the lower half.
//
// One triangle level streams entries 0..top out of memory, one per cycle.
// The previous entry is held in a register, so each newly read entry A and
// the held entry B form one interpolation step:
//   C = B + floor(t * (A - B) / 2^T_FRAC_BITS)
// The step runs in three registered stages: read data, difference, product.
// The sum is written back into the work store at the lower index. The first
// level reads the point store, the later ones the work store. Because a
// short level would read an entry before its new value is written back,
// the sequencer waits for the pipeline to drain between levels.
//
// The floor of the scaled product equals a plain slice of the full product
// taken above the fraction bits, since the result is wrapped to the
// coordinate width anyway.
//
// The result sits in an output register, so a new word is taken while the
// previous result still waits for the consumer.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_top
  import bpe_pkg::*;
#(
  parameter int MAX_POINTS  = BPE_MAX_POINTS,
  parameter int COORD_BITS  = BPE_COORD_BITS,
  parameter int T_FRAC_BITS = BPE_T_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [INDEX_BITS-1:0]         point_index,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic [T_FRAC_BITS:0]          curve_t,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  curve_x,
  output logic signed [COORD_BITS-1:0]  curve_y
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = COORD_BITS;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int DW = CW + 1;            // difference width
  localparam int PW = CW + TW + 2;       // full product width
  localparam int EW = 2 * CW;            // packed entry width
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [DEGREE_BITS-1:0] curve_degree;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree <= CURVE_DEGREE_RESET;
    end else if (cfg_write && (paddr[2] == REG_CURVE_DEGREE)) begin
      curve_degree <= pwdata[DEGREE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CURVE_DEGREE) begin
      prdata = APB_DATA_W'(curve_degree);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  bpe_state_t    state, state_next;
  logic [AW-1:0] rd_addr, rd_addr_next;  // entry read this cycle
  logic [AW-1:0] top, top_next;          // last entry read in this level
  logic          first_lvl, first_lvl_next;
  logic [TW-1:0] t_reg, t_next;
  logic          issue;
  logic          load_out;
  logic          in_accept;
  logic          pipe_busy;

  // Clamped degree and parameter of an incoming evaluate word.
  logic [AW-1:0] deg_clamped;
  logic [TW-1:0] t_clamped;

  // Pipeline registers.
  logic                 p0_vld;
  logic [AW-1:0]        p0_idx;
  logic                 p1_vld;
  logic [AW-1:0]        p1_addr;
  logic signed [CW-1:0] p1_bx, p1_by;
  logic signed [DW-1:0] p1_dx, p1_dy;
  logic                 p2_vld;
  logic [AW-1:0]        p2_addr;
  logic signed [CW-1:0] p2_bx, p2_by;
  logic signed [PW-1:0] p2_px, p2_py;
  logic signed [CW-1:0] prev_x, prev_y;
  logic signed [CW-1:0] last_x, last_y;

  // Memories and their registered read data.
  logic [EW-1:0] pts_mem [MAX_POINTS];
  logic [EW-1:0] wrk_mem [MAX_POINTS];
  logic [EW-1:0] pts_rd, wrk_rd;

  // Combinational datapath values.
  logic signed [CW-1:0] val_x, val_y;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [CW-1:0] sum_x, sum_y;
  logic                 pts_we;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign pipe_busy = p0_vld || p1_vld || p2_vld;

  always_comb begin
    if (32'(curve_degree) > MAX_POINTS - 1) begin
      deg_clamped = AW'(MAX_POINTS - 1);
    end else begin
      deg_clamped = AW'(curve_degree);
    end
    t_clamped = (curve_t > T_ONE) ? T_ONE : curve_t;
  end

  always_comb begin
    state_next     = state;
    rd_addr_next   = rd_addr;
    top_next       = top;
    first_lvl_next = first_lvl;
    t_next         = t_reg;
    issue          = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (mode == MODE_EVAL)) begin
          t_next         = t_clamped;
          top_next       = deg_clamped;
          rd_addr_next   = '0;
          first_lvl_next = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        issue = 1'b1;
        if (rd_addr == top) begin
          state_next = ST_DRAIN;
        end else begin
          rd_addr_next = rd_addr + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (top <= AW'(1)) begin
            state_next = ST_DONE;
          end else begin
            top_next       = top - AW'(1);
            rd_addr_next   = '0;
            first_lvl_next = 1'b0;
            state_next     = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_addr   <= '0;
      top       <= '0;
      first_lvl <= 1'b0;
      p0_vld    <= 1'b0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
    end else begin
      state     <= state_next;
      rd_addr   <= rd_addr_next;
      top       <= top_next;
      first_lvl <= first_lvl_next;
      p0_vld    <= issue;
      p1_vld    <= p0_vld && (p0_idx != '0);
      p2_vld    <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    t_reg <= t_next;
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  assign pts_we = in_accept && (mode == MODE_LOAD) && (32'(point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts_mem[AW'(point_index)] <= {point_x, point_y};
    end
    pts_rd <= pts_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p2_vld) begin
      wrk_mem[p2_addr] <= {sum_x, sum_y};
    end
    wrk_rd <= wrk_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Interpolation datapath
  // --------------------------------------------------------------------------
  always_comb begin
    if (first_lvl) begin
      val_x = pts_rd[EW-1:CW];
      val_y = pts_rd[CW-1:0];
    end else begin
      val_x = wrk_rd[EW-1:CW];
      val_y = wrk_rd[CW-1:0];
    end
    prod_x = PW'($signed({1'b0, t_reg})) * PW'(p1_dx);
    prod_y = PW'($signed({1'b0, t_reg})) * PW'(p1_dy);
    sum_x  = p2_bx + p2_px[T_FRAC_BITS +: CW];
    sum_y  = p2_by + p2_py[T_FRAC_BITS +: CW];
  end

  always_ff @(posedge clk) begin
    p0_idx <= rd_addr;
    if (p0_vld) begin
      prev_x <= val_x;
      prev_y <= val_y;
    end
    // Stage one: difference against the held entry.
    p1_addr <= p0_idx - AW'(1);
    p1_bx   <= prev_x;
    p1_by   <= prev_y;
    p1_dx   <= DW'(val_x) - DW'(prev_x);
    p1_dy   <= DW'(val_y) - DW'(prev_y);
    // Stage two: scale the difference by t.
    p2_addr <= p1_addr;
    p2_bx   <= p1_bx;
    p2_by   <= p1_by;
    p2_px   <= prod_x;
    p2_py   <= prod_y;
    // The last value produced is the curve point; with degree zero it is
    // control point 0 itself.
    if (p2_vld) begin
      last_x <= sum_x;
      last_y <= sum_y;
    end else if (p0_vld && (top == '0)) begin
      last_x <= val_x;
      last_y <= val_y;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      curve_x <= last_x;
      curve_y <= last_y;
    end
  end

endmodule
